// ===== rtl/bsab_pkg.sv =====
package bsab_pkg;

  // fixed widths of the datapath
  localparam int FRAC_BITS = 8;
  localparam int MAX_SIDE  = 256;
  localparam int SIDE_W    = 9;
  localparam int POS_W     = 13;
  localparam int TH_W      = 13;
  localparam int TW_W      = 21;
  localparam int TWN_W     = 22;
  localparam int REL_W     = 14;
  localparam int NUM_W     = 30;
  localparam int QUO_W     = 16;
  localparam int REM_W     = 22;
  localparam int ADDR_W    = 16;
  localparam int TEX_DEPTH = 65536;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_H = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOD   = 3'd5;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BLEND = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] texel_address;
    logic [31:0] texel_data;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [31:0] dest_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_color;
    logic        covered;
  } out_item_t;

  // effective settings seen by the datapath
  typedef struct packed {
    logic                    busy;
    logic [SIDE_W-1:0]       sw;
    logic [SIDE_W-1:0]       sh;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TH_W-1:0]         th;
    logic [TW_W-1:0]         tw;
    logic [3:0][7:0]         pm;
  } cfg_t;

  // item info carried alongside the coordinate dividers
  typedef struct packed {
    logic              vld;
    logic              op;
    logic              cov;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       word;
  } side_t;

  typedef struct packed {
    logic            vld;
    logic            op;
    logic            cov;
    logic [7:0]      fx;
    logic [7:0]      fy;
    logic [31:0]     word;
    logic [3:0][31:0] tex;
  } texel_set_t;

  typedef struct packed {
    logic            vld;
    logic            op;
    logic            cov;
    logic [31:0]     word;
    logic [3:0][7:0] src;
  } src_t;

  // floor(x/255) for x below 65280
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [17:0] y;
    y = {1'b0, x} + {9'd0, x[16:8]} + 18'd1;
    return y[15:8];
  endfunction

  // (a*b+127)/255
  function automatic logic [7:0] mul255(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] x;
    x = ({9'd0, a} * {9'd0, b}) + 17'd127;
    return div255(x);
  endfunction

endpackage

// ===== rtl/bilinear_scaled_alpha_blit_top.sv =====
// blend path: stages 1 and 2, the dividers, stages A, B and C, the blend unit, the output register
// one item per cycle while in_stall is low; the coordinate dividers are 16-stage pipelines
// a write to source_width, source_height or target_height stalls input
// while the target width divider runs one bit per cycle
// reset: synchronous active-low rst_n clears valid bits and settings; texture memory is not cleared
module bilinear_scaled_alpha_blit_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsab_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsab_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bsab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  bsab_pkg::cfg_t       set_s;
  logic                 adv, acc;

  logic                 vld1_r, op1_r;
  logic [15:0]          addr1_r;
  logic [31:0]          word1_r;
  logic [bsab_pkg::REL_W-1:0] rx1_r, ry1_r, rx_nxt, ry_nxt;

  bsab_pkg::side_t      side2_r;
  logic [bsab_pkg::NUM_W-1:0] numx_r, numy_r;
  logic                 cov_nxt;
  logic [21:0]          px_prod, py_prod;

  bsab_pkg::side_t      side_r [bsab_pkg::QUO_W];
  logic [bsab_pkg::QUO_W-1:0] sx, sy;

  bsab_pkg::side_t      sa_side_r;
  logic [7:0]           ix_r, ix1_r, iy_r, iy1_r, fxa_r, fya_r;
  logic [7:0]           ix_nxt, ix1_nxt, iy_nxt, iy1_nxt, swm1, shm1;

  bsab_pkg::side_t      sb_side_r;
  logic [7:0]           fxb_r, fyb_r;
  logic [3:0][15:0]     ra_r;
  logic [16:0]          row0, row1;

  logic                 vldc_r, opc_r, covc_r;
  logic [7:0]           fxc_r, fyc_r;
  logic [31:0]          wordc_r;
  logic [3:0][31:0]     tex;
  bsab_pkg::texel_set_t ts;
  bsab_pkg::src_t       bo;

  logic                 out_valid_r;
  bsab_pkg::out_item_t  out_data_r;
  logic [31:0]          blended;
  logic [7:0]           inv_a;
  logic [8:0]           csum;

  bsab_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .set_o     (set_s)
  );

  // global advance: the whole pipe moves unless a finished result is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || set_s.busy;
  assign acc      = in_valid && !in_stall;

  // stage 1: offsets into the target rectangle
  assign rx_nxt = {2'b00, in_data.dest_x} - {set_s.pos_x[12], set_s.pos_x};
  assign ry_nxt = {2'b00, in_data.dest_y} - {set_s.pos_y[12], set_s.pos_y};

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else if (adv) vld1_r <= acc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r   <= in_data.operation;
      addr1_r <= in_data.texel_address;
      word1_r <= (in_data.operation == bsab_pkg::OP_WRITE) ? in_data.texel_data
                                                           : in_data.dest_color;
      rx1_r   <= rx_nxt;
      ry1_r   <= ry_nxt;
    end
  end

  // stage 2: coverage test and divider numerators
  assign cov_nxt = !rx1_r[13] && ({8'd0, rx1_r[12:0]} < set_s.tw) &&
                   !ry1_r[13] && (ry1_r[12:0] < set_s.th);
  assign px_prod = {9'd0, rx1_r[12:0]} * {13'd0, set_s.sw};
  assign py_prod = {9'd0, ry1_r[12:0]} * {13'd0, set_s.sh};

  always_ff @(posedge clk) begin
    if (!rst_n) side2_r.vld <= 1'b0;
    else if (adv) side2_r.vld <= vld1_r;
    if (adv) begin
      side2_r.op   <= op1_r;
      side2_r.cov  <= cov_nxt;
      side2_r.addr <= addr1_r;
      side2_r.word <= word1_r;
      numx_r       <= {px_prod, 8'd0};
      numy_r       <= {py_prod, 8'd0};
    end
  end

  // source coordinates with 8 fraction bits
  bsab_div u_div_x (
    .clk (clk),
    .adv (adv),
    .num (numx_r),
    .den (set_s.tw),
    .quo (sx)
  );

  bsab_div u_div_y (
    .clk (clk),
    .adv (adv),
    .num (numy_r),
    .den ({8'd0, set_s.th}),
    .quo (sy)
  );

  // item info rides beside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bsab_pkg::QUO_W; k++) side_r[k].vld <= 1'b0;
    end else if (adv) begin
      side_r[0] <= side2_r;
      for (int k = 1; k < bsab_pkg::QUO_W; k++) side_r[k] <= side_r[k-1];
    end
  end

  // stage A: clamp indexes to size-1
  assign swm1 = 8'(set_s.sw - 9'd1);
  assign shm1 = 8'(set_s.sh - 9'd1);

  always_comb begin
    ix_nxt  = (sx[15:8] > swm1) ? swm1 : sx[15:8];
    iy_nxt  = (sy[15:8] > shm1) ? shm1 : sy[15:8];
    ix1_nxt = ({1'b0, ix_nxt} + 9'd1 > {1'b0, swm1}) ? swm1 : 8'(ix_nxt + 8'd1);
    iy1_nxt = ({1'b0, iy_nxt} + 9'd1 > {1'b0, shm1}) ? shm1 : 8'(iy_nxt + 8'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sa_side_r.vld <= 1'b0;
    else if (adv) sa_side_r.vld <= side_r[bsab_pkg::QUO_W-1].vld;
    if (adv) begin
      sa_side_r.op   <= side_r[bsab_pkg::QUO_W-1].op;
      sa_side_r.cov  <= side_r[bsab_pkg::QUO_W-1].cov;
      sa_side_r.addr <= side_r[bsab_pkg::QUO_W-1].addr;
      sa_side_r.word <= side_r[bsab_pkg::QUO_W-1].word;
      ix_r  <= ix_nxt;
      ix1_r <= ix1_nxt;
      iy_r  <= iy_nxt;
      iy1_r <= iy1_nxt;
      fxa_r <= sx[7:0];
      fya_r <= sy[7:0];
    end
  end

  // stage B: texel word addresses
  assign row0 = {9'd0, iy_r} * {8'd0, set_s.sw};
  assign row1 = {9'd0, iy1_r} * {8'd0, set_s.sw};

  always_ff @(posedge clk) begin
    if (!rst_n) sb_side_r.vld <= 1'b0;
    else if (adv) sb_side_r.vld <= sa_side_r.vld;
    if (adv) begin
      sb_side_r.op   <= sa_side_r.op;
      sb_side_r.cov  <= sa_side_r.cov;
      sb_side_r.addr <= sa_side_r.addr;
      sb_side_r.word <= sa_side_r.word;
      fxb_r <= fxa_r;
      fyb_r <= fya_r;
      ra_r[0] <= 16'(row0 + {9'd0, ix_r});
      ra_r[1] <= 16'(row0 + {9'd0, ix1_r});
      ra_r[2] <= 16'(row1 + {9'd0, ix_r});
      ra_r[3] <= 16'(row1 + {9'd0, ix1_r});
    end
  end

  // stage C: texture memory read, texel writes land at the same stage
  bsab_tex u_tex (
    .clk   (clk),
    .adv   (adv),
    .we    (sb_side_r.vld && sb_side_r.op == bsab_pkg::OP_WRITE),
    .waddr (sb_side_r.addr),
    .wdata (sb_side_r.word),
    .raddr (ra_r),
    .rdata (tex)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vldc_r <= 1'b0;
    else if (adv) vldc_r <= sb_side_r.vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opc_r   <= sb_side_r.op;
      covc_r  <= sb_side_r.cov;
      fxc_r   <= fxb_r;
      fyc_r   <= fyb_r;
      wordc_r <= sb_side_r.word;
    end
  end

  assign ts.vld  = vldc_r;
  assign ts.op   = opc_r;
  assign ts.cov  = covc_r;
  assign ts.fx   = fxc_r;
  assign ts.fy   = fyc_r;
  assign ts.word = wordc_r;
  assign ts.tex  = tex;

  bsab_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .pm    (set_s.pm),
    .ts_i  (ts),
    .src_o (bo)
  );

  // premultiplied over, alpha forced to 255
  always_comb begin
    inv_a   = 8'd255 - bo.src[0];
    blended = {24'd0, 8'hFF};
    csum    = '0;
    for (int i = 1; i < 4; i++) begin
      csum = {1'b0, bsab_pkg::mul255(bo.word[8*i +: 8], inv_a)} + {1'b0, bo.src[i]};
      blended[8*i +: 8] = csum[8] ? 8'hFF : csum[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= bo.vld && bo.op == bsab_pkg::OP_BLEND;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.covered   <= bo.cov;
      out_data_r.out_color <= bo.cov ? blended : bo.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_alpha_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.covered |-> out_data.out_color[7:0] == 8'hFF)
    else $error("covered pixel without opaque alpha");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    set_s.busy |-> in_stall)
    else $error("input taken while target width is recomputed");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(out_data_r) && $stable(sb_side_r.addr))
    else $error("pipeline moved while held");
`endif

endmodule

// ===== rtl/bsab_cfg.sv =====
module bsab_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bsab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  output bsab_pkg::cfg_t                  set_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [bsab_pkg::SIDE_W-1:0] sw_r, sh_r, sw_e, sh_e;
  logic [bsab_pkg::POS_W-1:0]  px_r, py_r;
  logic [bsab_pkg::TH_W-1:0]   th_r;
  logic [31:0]                 mod_r;
  logic [bsab_pkg::TW_W-1:0]   tw_r;
  logic [3:0][7:0]             pm_r, pm_nxt;
  logic [1:0]                  st_r;
  logic [4:0]                  cnt_r;
  logic [bsab_pkg::SIDE_W-1:0] rem_r;
  logic [bsab_pkg::TWN_W-1:0]  num_r;
  logic [bsab_pkg::SIDE_W:0]   t;
  logic                        ge;
  logic                        size_wr;

  // source sizes saturated into 1..MAX_SIDE
  always_comb begin
    sw_e = sw_r;
    sh_e = sh_r;
    if (sw_r == '0) sw_e = 9'd1;
    else if (sw_r > 9'(bsab_pkg::MAX_SIDE)) sw_e = 9'(bsab_pkg::MAX_SIDE);
    if (sh_r == '0) sh_e = 9'd1;
    else if (sh_r > 9'(bsab_pkg::MAX_SIDE)) sh_e = 9'(bsab_pkg::MAX_SIDE);
  end

  // premultiplied modulation color
  always_comb begin
    pm_nxt[0] = mod_r[7:0];
    for (int i = 1; i < 4; i++) begin
      pm_nxt[i] = bsab_pkg::mul255(mod_r[8*i +: 8], mod_r[7:0]);
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r  <= 9'd1;
      sh_r  <= 9'd1;
      px_r  <= '0;
      py_r  <= '0;
      th_r  <= 13'd1;
      mod_r <= 32'hFFFF_FFFF;
      pm_r  <= '1;
    end else begin
      pm_r <= pm_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bsab_pkg::REG_SRC_W: sw_r  <= cfg_data[8:0];
          bsab_pkg::REG_SRC_H: sh_r  <= cfg_data[8:0];
          bsab_pkg::REG_POS_X: px_r  <= cfg_data[12:0];
          bsab_pkg::REG_POS_Y: py_r  <= cfg_data[12:0];
          bsab_pkg::REG_TGT_H: th_r  <= cfg_data[12:0];
          bsab_pkg::REG_MOD:   mod_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign size_wr = cfg_we && (cfg_index == bsab_pkg::REG_SRC_W ||
                              cfg_index == bsab_pkg::REG_SRC_H ||
                              cfg_index == bsab_pkg::REG_TGT_H);

  // target width divider, one quotient bit per cycle
  assign t  = {rem_r, num_r[bsab_pkg::TWN_W-1]};
  assign ge = t >= {1'b0, sh_e};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      tw_r  <= 21'd1;
      cnt_r <= '0;
      rem_r <= '0;
      num_r <= '0;
    end else if (size_wr) begin
      st_r <= ST_LOAD;
    end else begin
      unique case (st_r)
        ST_LOAD: begin
          num_r <= {13'd0, sw_e} * {9'd0, th_r};
          rem_r <= '0;
          cnt_r <= 5'(bsab_pkg::TWN_W);
          st_r  <= ST_RUN;
        end
        ST_RUN: begin
          num_r <= {num_r[bsab_pkg::TWN_W-2:0], ge};
          rem_r <= ge ? 9'(t - {1'b0, sh_e}) : t[8:0];
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            tw_r <= {num_r[bsab_pkg::TW_W-2:0], ge};
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign set_o.busy  = st_r != ST_IDLE;
  assign set_o.sw    = sw_e;
  assign set_o.sh    = sh_e;
  assign set_o.pos_x = px_r;
  assign set_o.pos_y = py_r;
  assign set_o.th    = th_r;
  assign set_o.tw    = tw_r;
  assign set_o.pm    = pm_r;

endmodule

// ===== rtl/bsab_div.sv =====
module bsab_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [bsab_pkg::NUM_W-1:0]    num,
  input  logic [bsab_pkg::TW_W-1:0]     den,
  output logic [bsab_pkg::QUO_W-1:0]    quo
);

  logic [bsab_pkg::REM_W-1:0] rem_r [bsab_pkg::QUO_W];
  logic [bsab_pkg::QUO_W-1:0] low_r [bsab_pkg::QUO_W];
  logic [bsab_pkg::QUO_W-1:0] q_r   [bsab_pkg::QUO_W];

  // one restoring step per stage, most significant quotient bit first
  for (genvar k = 0; k < bsab_pkg::QUO_W; k++) begin : g_stage
    logic [bsab_pkg::REM_W-1:0] rem_in;
    logic [bsab_pkg::QUO_W-1:0] low_in;
    logic [bsab_pkg::QUO_W-1:0] q_in;
    logic [bsab_pkg::REM_W-1:0] t;
    logic                       ge;

    if (k == 0) begin : g_first
      assign rem_in = {8'd0, num[bsab_pkg::NUM_W-1:bsab_pkg::QUO_W]};
      assign low_in = num[bsab_pkg::QUO_W-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign t  = {rem_in[bsab_pkg::REM_W-2:0], low_in[bsab_pkg::QUO_W-1-k]};
    assign ge = t >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? (t - {1'b0, den}) : t;
        low_r[k] <= low_in;
        q_r[k]   <= q_in | ({{(bsab_pkg::QUO_W-1){1'b0}}, ge} << (bsab_pkg::QUO_W-1-k));
      end
    end
  end

  assign quo = q_r[bsab_pkg::QUO_W-1] | (low_r[bsab_pkg::QUO_W-1] & '0);

endmodule

// ===== rtl/bsab_tex.sv =====
module bsab_tex (
  input  logic                               clk,
  input  logic                               adv,
  input  logic                               we,
  input  logic [bsab_pkg::ADDR_W-1:0]        waddr,
  input  logic [31:0]                        wdata,
  input  logic [3:0][bsab_pkg::ADDR_W-1:0]   raddr,
  output logic [3:0][31:0]                   rdata
);

  // two identical copies, two read ports each
  logic [31:0] mem_a [bsab_pkg::TEX_DEPTH];
  logic [31:0] mem_b [bsab_pkg::TEX_DEPTH];
  logic [31:0] rd0_r, rd1_r, rd2_r, rd3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (we) mem_a[waddr] <= wdata;
      rd0_r <= mem_a[raddr[0]];
      rd1_r <= mem_a[raddr[1]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (we) mem_b[waddr] <= wdata;
      rd2_r <= mem_b[raddr[2]];
      rd3_r <= mem_b[raddr[3]];
    end
  end

  assign rdata = {rd3_r, rd2_r, rd1_r, rd0_r};

endmodule

// ===== rtl/bsab_blend.sv =====
module bsab_blend (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic [3:0][7:0]         pm,
  input  bsab_pkg::texel_set_t    ts_i,
  output bsab_pkg::src_t          src_o
);

  logic             vld1_r, op1_r, cov1_r, vld2_r, op2_r, cov2_r;
  logic [31:0]      word1_r, word2_r;
  logic [7:0]       fy1_r;
  logic [3:0][16:0] top_r, bot_r, top_nxt, bot_nxt;
  logic [3:0][7:0]  s_r, s_nxt, src_nxt;
  logic [8:0]       wx0, wy0;
  logic [25:0]      v;
  bsab_pkg::src_t   src_r;

  // horizontal lerp
  always_comb begin
    wx0 = 9'd256 - {1'b0, ts_i.fx};
    for (int i = 0; i < 4; i++) begin
      top_nxt[i] = {9'd0, ts_i.tex[0][8*i +: 8]} * {8'd0, wx0}
                 + {9'd0, ts_i.tex[1][8*i +: 8]} * {9'd0, ts_i.fx};
      bot_nxt[i] = {9'd0, ts_i.tex[2][8*i +: 8]} * {8'd0, wx0}
                 + {9'd0, ts_i.tex[3][8*i +: 8]} * {9'd0, ts_i.fx};
    end
  end

  // vertical lerp and rounding
  always_comb begin
    wy0 = 9'd256 - {1'b0, fy1_r};
    v   = '0;
    for (int i = 0; i < 4; i++) begin
      v = {9'd0, top_r[i]} * {17'd0, wy0} + {9'd0, bot_r[i]} * {18'd0, fy1_r}
        + 26'd32768;
      s_nxt[i] = v[23:16];
    end
  end

  // modulation
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      src_nxt[i] = bsab_pkg::mul255(s_r[i], pm[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      src_r.vld <= 1'b0;
    end else if (adv) begin
      vld1_r    <= ts_i.vld;
      vld2_r    <= vld1_r;
      src_r.vld <= vld2_r;
    end
    if (adv) begin
      op1_r      <= ts_i.op;
      cov1_r     <= ts_i.cov;
      word1_r    <= ts_i.word;
      fy1_r      <= ts_i.fy;
      top_r      <= top_nxt;
      bot_r      <= bot_nxt;
      op2_r      <= op1_r;
      cov2_r     <= cov1_r;
      word2_r    <= word1_r;
      s_r        <= s_nxt;
      src_r.op   <= op2_r;
      src_r.cov  <= cov2_r;
      src_r.word <= word2_r;
      src_r.src  <= src_nxt;
    end
  end

  assign src_o = src_r;

endmodule
